@@ sv/isc_pkg.sv @@
// ----------------------------------------------------------------------------
// isc_pkg: integer stack calculator shared definitions
// Command and status codes, sequencer states and the transaction payloads.
// ----------------------------------------------------------------------------
package isc_pkg;

  // Word and stack geometry
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STACK_DEPTH = 256;
  localparam int unsigned ADDR_W      = $clog2(STACK_DEPTH);
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IDX_W       = 8;
  localparam int unsigned STEP_W      = $clog2(WORD_W);

  typedef enum logic [2:0] {
    CMD_PUSH     = 3'd0,
    CMD_POP      = 3'd1,
    CMD_PEEK_TOP = 3'd2,
    CMD_PEEK_BOT = 3'd3,
    CMD_ADD      = 3'd4,
    CMD_SUB      = 3'd5,
    CMD_MUL      = 3'd6,
    CMD_DIV      = 3'd7
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_EMPTY   = 3'd1,
    ST_RANGE   = 3'd2,
    ST_FEW     = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_FULL    = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ1,
    S_READ2,
    S_MUL,
    S_DIV,
    S_DONE
  } state_e;

  typedef struct packed {
    cmd_e                     cmd;
    logic signed [WORD_W-1:0] push_value;
    logic [IDX_W-1:0]         peek_index;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] result_value;
    status_e                  status;
    logic [CNT_W-1:0]         stack_count;
  } out_t;

endpackage

@@ sv/isc_div.sv @@
// ----------------------------------------------------------------------------
// isc_div: floor divider
// Radix-2 restoring division on magnitudes, one quotient bit per cycle,
// with the sign and the round-toward-minus-infinity fix applied at the end.
// ----------------------------------------------------------------------------
module isc_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic signed [isc_pkg::WORD_W-1:0] num_i,
  input  logic signed [isc_pkg::WORD_W-1:0] den_i,
  output logic                              done_o,
  output logic signed [isc_pkg::WORD_W-1:0] quot_o
);

  localparam int unsigned W  = isc_pkg::WORD_W;
  localparam int unsigned SW = isc_pkg::STEP_W;

  logic          busy_q, busy_d;
  logic          done_q, done_d;
  logic [SW-1:0] cnt_q, cnt_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [W-1:0]  quo_q, quo_d;
  logic [W-1:0]  den_q, den_d;
  logic          neg_q, neg_d;

  logic [W:0]    shifted;
  logic [W:0]    diff;

  assign shifted = {rem_q, quo_q[W-1]};
  assign diff    = shifted - {1'b0, den_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    neg_d  = neg_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = num_i[W-1] ? W'(-num_i) : W'(num_i);
      den_d  = den_i[W-1] ? W'(-den_i) : W'(den_i);
      neg_d  = num_i[W-1] ^ den_i[W-1];
    end else if (busy_q) begin
      // keep the trial difference when it does not go negative
      if (!diff[W]) begin
        rem_d = diff[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b1};
      end else begin
        rem_d = shifted[W-1:0];
        quo_d = {quo_q[W-2:0], 1'b0};
      end
      cnt_d = cnt_q + SW'(1);
      if (cnt_q == SW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
    neg_q <= neg_d;
  end

  // negative with a remainder: -q - 1 is ~q
  always_comb begin
    if (!neg_q) begin
      quot_o = quo_q;
    end else if (rem_q != '0) begin
      quot_o = ~quo_q;
    end else begin
      quot_o = -quo_q;
    end
  end

  assign done_o = done_q;

endmodule

@@ sv/integer_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// integer_stack_calculator: bounded RPN stack of signed 32-bit words
// Push, pop, peek from top or bottom, and add/sub/mul/floor-div of the top
// two words, with the stack held in one synchronous single-port memory.
// ----------------------------------------------------------------------------
//
//   channel  | direction | handshake                | payload
//   ---------+-----------+--------------------------+-----------------------
//   command  | in        | in_valid_i / in_ready_o  | in_data_i  (isc_pkg::in_t)
//   result   | out       | out_valid_o / out_ready_i| out_data_o (isc_pkg::out_t)
//
// One command in flight; the single memory port reads the top two words in turn.
// Per command: push and every early error go S_IDLE to S_DONE, pop and peeks add
// S_READ1, two-word ops add S_READ2, mul S_MUL, a nonzero div S_DIV (one quotient bit per cycle).
// Reset clears the word count and the control state; the memory is not cleared.
// A result waits in the output register while the next command runs; a
// stalled output holds the sequencer in S_DONE.
// ----------------------------------------------------------------------------
module integer_stack_calculator (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  isc_pkg::in_t   in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output isc_pkg::out_t  out_data_o
);

  localparam int unsigned W  = isc_pkg::WORD_W;
  localparam int unsigned AW = isc_pkg::ADDR_W;
  localparam int unsigned CW = isc_pkg::CNT_W;

  // Sequencer and command registers
  isc_pkg::state_e  state_q, state_d;
  isc_pkg::cmd_e    cmd_q, cmd_d;
  isc_pkg::status_e status_q, status_d;
  logic [W-1:0]     pv_q, pv_d;
  logic [W-1:0]     value_q, value_d;
  logic [W-1:0]     top_q, top_d;
  logic [W-1:0]     next_q, next_d;
  logic [CW-1:0]    count_q, count_d;

  // Output register
  logic             out_valid_q, out_valid_d;
  isc_pkg::out_t    out_data_q, out_data_d;
  logic             out_free;

  // Stack memory
  logic [W-1:0]     mem [isc_pkg::STACK_DEPTH];
  logic             mem_rd_en;
  logic [AW-1:0]    mem_rd_addr;
  logic [W-1:0]     mem_rdata_q;
  logic             mem_wr_en;
  logic [AW-1:0]    mem_wr_addr;
  logic [W-1:0]     mem_wr_data;

  // Divider handshake
  logic             div_start;
  logic             div_done;
  logic [W-1:0]     div_quot;

  // Command decode helpers
  isc_pkg::status_e early_status;
  logic [CW-1:0]    idx_ext;
  logic [CW-1:0]    cnt_m1;
  logic [CW-1:0]    cnt_m2;
  logic [CW-1:0]    peek_top_addr;
  logic [W-1:0]     mul_lo;
  logic             in_accept;

  assign in_accept     = in_valid_i && in_ready_o;
  assign out_free      = !out_valid_q || out_ready_i;
  assign idx_ext       = CW'(in_data_i.peek_index);
  assign cnt_m1        = count_q - CW'(1);
  assign cnt_m2        = count_q - CW'(2);
  assign peek_top_addr = cnt_m1 - idx_ext;
  assign mul_lo        = next_q * top_q;

  // Check a fresh command against the current word count
  always_comb begin
    early_status = isc_pkg::ST_OK;
    unique case (in_data_i.cmd) inside
      isc_pkg::CMD_PUSH: begin
        if (count_q >= CW'(isc_pkg::STACK_DEPTH)) early_status = isc_pkg::ST_FULL;
      end
      isc_pkg::CMD_POP: begin
        if (count_q == '0) early_status = isc_pkg::ST_EMPTY;
      end
      isc_pkg::CMD_PEEK_TOP, isc_pkg::CMD_PEEK_BOT: begin
        if (idx_ext >= count_q) early_status = isc_pkg::ST_RANGE;
      end
      default: begin
        if (count_q < CW'(2)) early_status = isc_pkg::ST_FEW;
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      isc_pkg::S_IDLE: begin
        if (in_valid_i) begin
          if (early_status != isc_pkg::ST_OK || in_data_i.cmd == isc_pkg::CMD_PUSH) begin
            state_d = isc_pkg::S_DONE;
          end else begin
            state_d = isc_pkg::S_READ1;
          end
        end
      end
      isc_pkg::S_READ1: begin
        state_d = cmd_q[2] ? isc_pkg::S_READ2 : isc_pkg::S_DONE;
      end
      isc_pkg::S_READ2: begin
        unique case (cmd_q) inside
          isc_pkg::CMD_MUL: state_d = isc_pkg::S_MUL;
          isc_pkg::CMD_DIV: state_d = (top_q == '0) ? isc_pkg::S_DONE : isc_pkg::S_DIV;
          default:          state_d = isc_pkg::S_DONE;
        endcase
      end
      isc_pkg::S_MUL: state_d = isc_pkg::S_DONE;
      isc_pkg::S_DIV: begin
        if (div_done) state_d = isc_pkg::S_DONE;
      end
      isc_pkg::S_DONE: begin
        if (out_free) state_d = isc_pkg::S_IDLE;
      end
      default: state_d = isc_pkg::S_IDLE;
    endcase
  end

  // Datapath, memory control and output register load
  always_comb begin
    cmd_d       = cmd_q;
    status_d    = status_q;
    pv_d        = pv_q;
    value_d     = value_q;
    top_d       = top_q;
    next_d      = next_q;
    count_d     = count_q;
    mem_rd_en   = 1'b0;
    mem_rd_addr = '0;
    mem_wr_en   = 1'b0;
    mem_wr_addr = '0;
    mem_wr_data = value_q;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_data_d  = out_data_q;
    in_ready_o  = 1'b0;

    unique case (state_q)
      isc_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_accept) begin
          cmd_d    = in_data_i.cmd;
          pv_d     = in_data_i.push_value;
          status_d = early_status;
          value_d  = '0;
          // issue the first read; push needs none
          unique case (in_data_i.cmd) inside
            isc_pkg::CMD_PUSH:     mem_rd_addr = '0;
            isc_pkg::CMD_PEEK_TOP: mem_rd_addr = peek_top_addr[AW-1:0];
            isc_pkg::CMD_PEEK_BOT: mem_rd_addr = idx_ext[AW-1:0];
            default:               mem_rd_addr = cnt_m1[AW-1:0];
          endcase
          mem_rd_en = (early_status == isc_pkg::ST_OK) &&
                      (in_data_i.cmd != isc_pkg::CMD_PUSH);
        end
      end
      isc_pkg::S_READ1: begin
        if (cmd_q[2]) begin
          // top word in hand; fetch the one below it
          top_d       = mem_rdata_q;
          mem_rd_en   = 1'b1;
          mem_rd_addr = cnt_m2[AW-1:0];
        end else begin
          value_d = mem_rdata_q;
        end
      end
      isc_pkg::S_READ2: begin
        next_d = mem_rdata_q;
        unique case (cmd_q) inside
          isc_pkg::CMD_ADD: value_d = mem_rdata_q + top_q;
          isc_pkg::CMD_SUB: value_d = mem_rdata_q - top_q;
          isc_pkg::CMD_DIV: begin
            if (top_q == '0) begin
              status_d = isc_pkg::ST_DIVZERO;
            end else begin
              div_start = 1'b1;
            end
          end
          default: value_d = value_q;
        endcase
      end
      isc_pkg::S_MUL: begin
        value_d = mul_lo;
      end
      isc_pkg::S_DIV: begin
        if (div_done) value_d = div_quot;
      end
      isc_pkg::S_DONE: begin
        if (out_free) begin
          // commit the stack update together with the result
          if (status_q == isc_pkg::ST_OK) begin
            unique case (cmd_q) inside
              isc_pkg::CMD_PUSH: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = count_q[AW-1:0];
                mem_wr_data = pv_q;
                count_d     = count_q + CW'(1);
              end
              isc_pkg::CMD_POP: count_d = cnt_m1;
              isc_pkg::CMD_PEEK_TOP, isc_pkg::CMD_PEEK_BOT: count_d = count_q;
              default: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = cnt_m2[AW-1:0];
                count_d     = cnt_m1;
              end
            endcase
          end else if (status_q == isc_pkg::ST_DIVZERO) begin
            count_d = cnt_m2;
          end
          out_valid_d             = 1'b1;
          out_data_d.result_value = value_q;
          out_data_d.status       = status_q;
          out_data_d.stack_count  = count_d;
        end
      end
      default: begin
        value_d = value_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isc_pkg::S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    status_q   <= status_d;
    pv_q       <= pv_d;
    value_q    <= value_d;
    top_q      <= top_d;
    next_q     <= next_d;
    out_data_q <= out_data_d;
  end

  // Stack memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (mem_wr_en) begin
      mem[mem_wr_addr] <= mem_wr_data;
    end
    if (mem_rd_en) begin
      mem_rdata_q <= mem[mem_rd_addr];
    end
  end

  isc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (next_d),
    .den_i   (top_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

@@ verif/tb_integer_stack_calculator.sv @@
// ----------------------------------------------------------------------------
// tb_integer_stack_calculator: self-checking bench for the RPN stack calculator
// Drives command transactions with random gaps, stalls the result channel at
// random, and checks every result against a cycle-free software stack.
// ----------------------------------------------------------------------------
module tb_integer_stack_calculator;

  localparam int unsigned       WORD_W      = isc_pkg::WORD_W;
  localparam int unsigned       IDX_W       = isc_pkg::IDX_W;
  localparam int unsigned       CNT_W       = isc_pkg::CNT_W;
  localparam int unsigned       STACK_DEPTH = isc_pkg::STACK_DEPTH;
  localparam logic [WORD_W-1:0] WORD_MIN   = 32'h8000_0000;
  localparam logic [WORD_W-1:0] WORD_MAX   = 32'h7FFF_FFFF;
  localparam int unsigned       RAND_ITEMS = 1100;
  // Slowest transaction is a divide behind the longest sender gap and the
  // longest result stall; allow many times that without any progress.
  localparam int unsigned       IDLE_LIMIT = 2000;
  localparam int unsigned       DRAIN_WAIT = 60;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  isc_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  isc_pkg::out_t out_data_o;

  integer_stack_calculator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Commands waiting to be sent, and results the stack has yet to return.
  isc_pkg::in_t  pending_cmds[$];
  isc_pkg::out_t expected_results[$];

  // Software copy of the stack, advanced once per accepted command.
  logic [WORD_W-1:0] calc_stack [STACK_DEPTH];
  int unsigned       calc_depth = 0;

  // Upper bound on the stack depth seen by the stimulus builder; it cannot
  // know divide-by-zero outcomes, so it only shapes the command mix.
  int unsigned est_depth = 0;
  int unsigned gen_count = 0;

  int unsigned error_count = 0;
  int unsigned send_gap    = 0;
  int unsigned stall_left  = 0;
  int unsigned idle_cycles = 0;

  // Calm stretches suppress all gaps and stalls on both channels.
  logic        calm      = 1'b0;
  int unsigned calm_left = 300;

  // --------------------------------------------------------------------------
  // Result prediction
  // --------------------------------------------------------------------------

  // Apply one command to the software stack and queue the result it yields.
  task automatic calc_expected_result(input isc_pkg::in_t cmd_item);
    isc_pkg::out_t     res;
    logic [WORD_W-1:0] top_w;
    logic [WORD_W-1:0] below_w;
    longint            num;
    longint            den;
    longint            quo;
    res              = '0;
    res.status       = isc_pkg::ST_OK;
    case (cmd_item.cmd)
      isc_pkg::CMD_PUSH: begin
        if (calc_depth >= STACK_DEPTH) begin
          res.status = isc_pkg::ST_FULL;
        end else begin
          calc_stack[calc_depth] = cmd_item.push_value;
          calc_depth++;
        end
      end
      isc_pkg::CMD_POP: begin
        if (calc_depth == 0) begin
          res.status = isc_pkg::ST_EMPTY;
        end else begin
          calc_depth--;
          res.result_value = calc_stack[calc_depth];
        end
      end
      isc_pkg::CMD_PEEK_TOP: begin
        if (cmd_item.peek_index < calc_depth) begin
          res.result_value = calc_stack[calc_depth - 1 - cmd_item.peek_index];
        end else begin
          res.status = isc_pkg::ST_RANGE;
        end
      end
      isc_pkg::CMD_PEEK_BOT: begin
        if (cmd_item.peek_index < calc_depth) begin
          res.result_value = calc_stack[cmd_item.peek_index];
        end else begin
          res.status = isc_pkg::ST_RANGE;
        end
      end
      default: begin
        if (calc_depth < 2) begin
          res.status = isc_pkg::ST_FEW;
        end else begin
          top_w      = calc_stack[calc_depth - 1];
          below_w    = calc_stack[calc_depth - 2];
          calc_depth = calc_depth - 2;
          case (cmd_item.cmd)
            isc_pkg::CMD_ADD: res.result_value = below_w + top_w;
            isc_pkg::CMD_SUB: res.result_value = below_w - top_w;
            isc_pkg::CMD_MUL: res.result_value = below_w * top_w;
            default: begin
              if (top_w == '0) begin
                res.status = isc_pkg::ST_DIVZERO;
              end else begin
                // Truncating divide, then step down when the remainder's
                // sign disagrees with the divisor's (floor rounding).
                num = longint'($signed(below_w));
                den = longint'($signed(top_w));
                quo = num / den;
                if ((num % den) != 0 && (((num % den) < 0) != (den < 0))) begin
                  quo = quo - 1;
                end
                res.result_value = quo[WORD_W-1:0];
              end
            end
          endcase
          // Divide by zero consumes both operands and pushes nothing.
          if (res.status == isc_pkg::ST_OK) begin
            calc_stack[calc_depth] = res.result_value;
            calc_depth++;
          end
        end
      end
    endcase
    res.stack_count = calc_depth[CNT_W-1:0];
    expected_results.push_back(res);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Mostly extremes and small words, so divides and overflows land often.
  function automatic logic [WORD_W-1:0] rand_word();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 12) begin
      case ($urandom_range(0, 4))
        0:       return WORD_MIN;
        1:       return WORD_MAX;
        2:       return '0;
        3:       return '1;
        default: return 32'd1;
      endcase
    end
    if (r < 55) return $urandom_range(0, 200) - 100;
    return $urandom();
  endfunction

  // Mostly an index that hits a live word, otherwise anything in range.
  function automatic logic [IDX_W-1:0] rand_index();
    if (est_depth > 0 && $urandom_range(0, 9) < 8) begin
      return IDX_W'($urandom_range(0, est_depth - 1));
    end
    return IDX_W'($urandom_range(0, 255));
  endfunction

  function automatic isc_pkg::cmd_e pick_cmd();
    int unsigned w;
    w = $urandom_range(0, 99);
    if (est_depth < 2 && w < 50) return isc_pkg::CMD_PUSH;
    if (w < 34) return isc_pkg::CMD_PUSH;
    if (w < 44) return isc_pkg::CMD_POP;
    if (w < 51) return isc_pkg::CMD_PEEK_TOP;
    if (w < 58) return isc_pkg::CMD_PEEK_BOT;
    if (w < 69) return isc_pkg::CMD_ADD;
    if (w < 79) return isc_pkg::CMD_SUB;
    if (w < 89) return isc_pkg::CMD_MUL;
    return isc_pkg::CMD_DIV;
  endfunction

  function automatic isc_pkg::cmd_e rand_arith();
    return isc_pkg::cmd_e'($urandom_range(isc_pkg::CMD_ADD, isc_pkg::CMD_DIV));
  endfunction

  task automatic queue_cmd(input isc_pkg::cmd_e c, input logic [WORD_W-1:0] v = '0,
                           input logic [IDX_W-1:0] ix = '0);
    isc_pkg::in_t it;
    it.cmd        = c;
    it.push_value = v;
    it.peek_index = ix;
    pending_cmds.push_back(it);
    gen_count++;
    case (c)
      isc_pkg::CMD_PUSH:                            if (est_depth < STACK_DEPTH) est_depth++;
      isc_pkg::CMD_POP:                             if (est_depth > 0) est_depth--;
      isc_pkg::CMD_PEEK_TOP, isc_pkg::CMD_PEEK_BOT: ;
      default:                                      if (est_depth >= 2) est_depth--;
    endcase
  endtask

  // Empty the stack, then poke it while empty; afterwards the depth is known
  // to be exactly zero.
  task automatic drain_stack();
    int unsigned w;
    while (est_depth > 0) begin
      w = $urandom_range(0, 9);
      if (w < 6) begin
        queue_cmd(isc_pkg::CMD_POP);
      end else if (w < 9) begin
        queue_cmd(rand_arith());
      end else begin
        queue_cmd(isc_pkg::CMD_PEEK_TOP, '0, rand_index());
      end
    end
    queue_cmd(isc_pkg::CMD_POP);
    queue_cmd(isc_pkg::CMD_POP);
    queue_cmd(rand_arith());
    queue_cmd(isc_pkg::CMD_PEEK_BOT, '0, rand_index());
    est_depth = 0;
  endtask

  // Push to the depth limit, overflow it, and work at the very edges.
  task automatic fill_stack();
    while (est_depth < STACK_DEPTH) begin
      if ($urandom_range(0, 19) == 0) begin
        queue_cmd(isc_pkg::CMD_PEEK_BOT, '0, rand_index());
      end else begin
        queue_cmd(isc_pkg::CMD_PUSH, rand_word());
      end
    end
    repeat (3) queue_cmd(isc_pkg::CMD_PUSH, rand_word());
    queue_cmd(isc_pkg::CMD_PEEK_BOT, '0, 8'd255);
    queue_cmd(isc_pkg::CMD_PEEK_TOP, '0, 8'd255);
    queue_cmd(isc_pkg::CMD_PEEK_TOP, '0, 8'd0);
    queue_cmd(isc_pkg::CMD_PEEK_BOT, '0, rand_index());
    queue_cmd(isc_pkg::CMD_MUL);
    queue_cmd(isc_pkg::CMD_PUSH, rand_word());
    queue_cmd(isc_pkg::CMD_PUSH, rand_word());
    queue_cmd(isc_pkg::CMD_DIV);
  endtask

  task automatic check_field(input string name, input logic [WORD_W-1:0] exp_v,
                             input logic [WORD_W-1:0] act_v);
    if (exp_v !== act_v) begin
      error_count++;
      $error("%s: expected %0d, actual %0d", name, $signed(exp_v), $signed(act_v));
    end
  endtask

  // --------------------------------------------------------------------------
  // Command driver: present the next pending transaction after its gap, hold
  // it until accepted, and hand every accepted command to the predictor.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i  <= '0;
      send_gap   = 0;
    end else begin
      if (in_valid_i && in_ready_o) calc_expected_result(in_data_i);
      // Advance only when nothing is on the bus or it was just taken.
      if (!in_valid_i || in_ready_o) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid_i <= 1'b0;
        end else if (pending_cmds.size() > 0) begin
          in_data_i  <= pending_cmds.pop_front();
          in_valid_i <= 1'b1;
          send_gap   = draw_gap();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side: stall ready at random, independent of out_valid_o.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
      stall_left  = draw_gap();
    end
  end

  // Toggle between calm stretches (no gaps) and normal traffic.
  always @(posedge clk_i) begin
    if (calm_left == 0) begin
      calm      <= ~calm;
      calm_left <= calm ? $urandom_range(200, 800) : $urandom_range(50, 200);
    end else begin
      calm_left <= calm_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: compare each accepted result with the oldest expectation.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    isc_pkg::out_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_results.size() == 0) begin
        error_count++;
        $error("result transaction with no command outstanding");
      end else begin
        exp_res = expected_results.pop_front();
        check_field("result_value", exp_res.result_value, out_data_o.result_value);
        check_field("status", WORD_W'(exp_res.status), WORD_W'(out_data_o.status));
        check_field("stack_count", WORD_W'(exp_res.stack_count),
                    WORD_W'(out_data_o.stack_count));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: end the run when neither channel moves for too long.
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_integer_stack_calculator failed");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus and end of test
  // --------------------------------------------------------------------------
  initial begin
    int unsigned episode;
    int unsigned fills;
    int unsigned start_count;
    int unsigned r;

    // Directed: every error path on an empty stack, the most negative word
    // divided by minus one, floor rounding for mixed signs, divide by zero,
    // and peeks at both ends.
    queue_cmd(isc_pkg::CMD_POP);
    queue_cmd(isc_pkg::CMD_PEEK_TOP, '0, 8'd0);
    queue_cmd(isc_pkg::CMD_PEEK_BOT, '0, 8'd255);
    queue_cmd(isc_pkg::CMD_ADD);
    queue_cmd(isc_pkg::CMD_PUSH, WORD_MIN);
    queue_cmd(isc_pkg::CMD_DIV);
    queue_cmd(isc_pkg::CMD_PUSH, '1);
    queue_cmd(isc_pkg::CMD_DIV);
    queue_cmd(isc_pkg::CMD_PUSH, WORD_MAX);
    queue_cmd(isc_pkg::CMD_ADD);
    queue_cmd(isc_pkg::CMD_PUSH, WORD_MAX);
    queue_cmd(isc_pkg::CMD_MUL);
    queue_cmd(isc_pkg::CMD_PUSH, 32'd7);
    queue_cmd(isc_pkg::CMD_PUSH, -32'sd2);
    queue_cmd(isc_pkg::CMD_DIV);
    queue_cmd(isc_pkg::CMD_SUB);
    queue_cmd(isc_pkg::CMD_PUSH, '0);
    queue_cmd(isc_pkg::CMD_DIV);
    queue_cmd(isc_pkg::CMD_PUSH, -32'sd7);
    queue_cmd(isc_pkg::CMD_PUSH, 32'd2);
    queue_cmd(isc_pkg::CMD_DIV);
    queue_cmd(isc_pkg::CMD_PUSH, 32'd123);
    queue_cmd(isc_pkg::CMD_PEEK_TOP, '0, 8'd1);
    queue_cmd(isc_pkg::CMD_PEEK_BOT, '0, 8'd0);
    queue_cmd(isc_pkg::CMD_PEEK_BOT, '0, 8'd2);
    queue_cmd(isc_pkg::CMD_POP);

    // Random: mostly mixed traffic on a live stack, with drains to empty and
    // at least one climb to the depth limit.
    episode     = 0;
    fills       = 0;
    start_count = gen_count;
    while (gen_count - start_count < RAND_ITEMS) begin
      r = $urandom_range(0, 9);
      if ((episode == 2 || r == 0) && fills < 2) begin
        drain_stack();
        fill_stack();
        fills++;
      end else if (r <= 2) begin
        drain_stack();
      end else begin
        repeat ($urandom_range(20, 60)) queue_cmd(pick_cmd(), rand_word(), rand_index());
      end
      episode++;
    end

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every command is taken and every result has come back.
    while (pending_cmds.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_integer_stack_calculator passed");
    end else begin
      $display("tb_integer_stack_calculator failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/isc_pkg.sv
sv/isc_div.sv
sv/integer_stack_calculator.sv
verif/tb_integer_stack_calculator.sv
